### design/prts_pkg.sv
`timescale 1ns / 1ps
package prts_pkg;

   // Slot table geometry
   localparam int SLOTS  = 8;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = 16;
   localparam int KIND_W = 3;
   localparam int SLOT_W = 3;
   localparam int MASK_W = 8;

   // Command codes carried in the request tuser
   typedef enum logic [KIND_W-1:0] {
      KIND_TICK    = 3'd0,
      KIND_CREATE  = 3'd1,
      KIND_SUSPEND = 3'd2,
      KIND_RESUME  = 3'd3,
      KIND_DELETE  = 3'd4
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } state_type;

   // One memory entry: stored period over countdown
   typedef struct packed {
      logic [CNT_W-1:0] per;
      logic [CNT_W-1:0] cd;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // What the sweep sees of one slot
   typedef struct packed {
      logic      active;
      logic      occupied;
      logic      written;
      entry_type entry;
   } slot_view_type;

   // What the sweep does to one slot
   typedef struct packed {
      logic      wr;
      logic      release_hit;
      entry_type entry;
   } slot_upd_type;

endpackage

### design/periodic_task_release_scheduler.sv
`timescale 1ns / 1ps
// Create, suspend, resume and delete answer in the cycle after acceptance.
// A tick answers once the sweep ends: the sweep visits one slot a
// cycle through the single read port of the countdown/period memory.
// Throughput: one command per cycle while the result register is free or drains; none during a sweep.
// Reset empties all slots and clears the active and written marks at once; the
// memory itself is not cleared, unwritten entries read as zero.
module periodic_task_release_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // slot[2:0], period[18:3], first_delay[34:19], zero fill
   input  logic [2:0]  req_tuser,  // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // status[0], release_mask[8:1], zero fill
);
   import prts_pkg::*;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SLOTS-1:0]  occ_ff, occ_in;
   logic [SLOTS-1:0]  act_ff, act_in;
   logic [SLOTS-1:0]  wrt_ff, wrt_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [MASK_W-1:0] rsp_mask_ff, rsp_mask_in;

   logic              ram_we, ram_re;
   logic [IDX_W-1:0]  ram_waddr, ram_raddr;
   entry_type         ram_wdata, ram_rdata;

   logic [SLOT_W-1:0] req_slot;
   logic [CNT_W-1:0]  req_period;
   logic [CNT_W-1:0]  req_first;
   logic [IDX_W-1:0]  req_idx;
   logic              in_range;
   logic              accept;
   logic              last_slot;
   logic              sweep_done;
   slot_view_type     view;
   slot_upd_type      upd;

   // Unpack the request item
   assign req_slot   = req_tdata[2:0];
   assign req_period = req_tdata[18:3];
   assign req_first  = req_tdata[34:19];
   assign req_idx    = IDX_W'(req_slot);
   assign in_range   = int'(req_slot) < SLOTS;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign last_slot  = idx_ff == IDX_W'(SLOTS - 1);
   assign sweep_done = (state_ff == ST_SWEEP) && last_slot;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_mask_ff, rsp_status_ff};

   // Slot under the sweep
   assign view.active   = act_ff[idx_ff];
   assign view.occupied = occ_ff[idx_ff];
   assign view.written  = wrt_ff[idx_ff];
   assign view.entry    = ram_rdata;

   prts_upd u_upd (
      .view (view),
      .upd  (upd)
   );

   prts_ram #(
      .DEPTH  (SLOTS),
      .WIDTH  (ENTRY_W),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Command decode, sweep sequencing and result register
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      occ_in        = occ_ff;
      act_in        = act_ff;
      wrt_in        = wrt_ff;
      mask_in       = mask_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_mask_in   = rsp_mask_ff;
      ram_we        = 1'b0;
      ram_waddr     = req_idx;
      ram_wdata.per = req_period;
      ram_wdata.cd  = req_first;
      ram_re        = 1'b0;
      ram_raddr     = '0;

      // Drain the result register
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_status_in = 1'b0;
               rsp_mask_in   = '0;
               if (req_tuser == KIND_TICK) begin
                  // Start the sweep at slot zero
                  ram_re   = 1'b1;
                  idx_in   = '0;
                  mask_in  = '0;
                  state_in = ST_SWEEP;
               end else begin
                  rsp_valid_in = 1'b1;
                  if (req_tuser == KIND_CREATE) begin
                     if (!in_range || occ_ff[req_idx]) begin
                        rsp_status_in = 1'b1;
                     end else begin
                        ram_we          = 1'b1;
                        occ_in[req_idx] = 1'b1;
                        act_in[req_idx] = 1'b1;
                        wrt_in[req_idx] = 1'b1;
                     end
                  end else if (req_tuser == KIND_SUSPEND) begin
                     if (in_range) begin
                        act_in[req_idx] = 1'b0;
                     end
                  end else if (req_tuser == KIND_RESUME) begin
                     if (in_range) begin
                        act_in[req_idx] = 1'b1;
                     end
                  end else if (req_tuser == KIND_DELETE) begin
                     if (in_range) begin
                        occ_in[req_idx] = 1'b0;
                     end
                  end
               end
            end
         end
         ST_SWEEP: begin
            // Write back this slot, read the next one unless this is the last
            ram_we    = upd.wr;
            ram_waddr = idx_ff;
            ram_wdata = upd.entry;
            if (upd.release_hit && (int'(idx_ff) < MASK_W)) begin
               mask_in = mask_ff | (MASK_W'(1) << idx_ff);
            end
            if (last_slot) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b0;
               rsp_mask_in   = mask_in;
               state_in      = ST_IDLE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = idx_ff + IDX_W'(1);
               idx_in    = idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         act_ff       <= '0;
         wrt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         act_ff       <= act_in;
         wrt_ff       <= wrt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      mask_ff       <= mask_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mask_ff   <= rsp_mask_in;
   end

`ifndef SYNTHESIS
   a_no_rw_same_entry: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("memory read and write hit the same entry");

   a_tick_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == KIND_TICK) |=> (state_ff == ST_SWEEP && idx_ff == '0))
      else $error("tick did not start a sweep at slot zero");

   a_sweep_ends_in_result: assert property (@(posedge clock) disable iff (reset)
      sweep_done |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("sweep finished without a result");

   a_result_free_at_sweep_end: assert property (@(posedge clock) disable iff (reset)
      sweep_done |-> !rsp_valid_ff)
      else $error("result register busy when sweep finished");

   a_no_release_of_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && upd.release_hit) |-> (view.occupied && view.active))
      else $error("released a slot that is empty or suspended");
`endif

endmodule

### design/prts_ram.sv
`timescale 1ns / 1ps
module prts_ram #(
   parameter int DEPTH  = 8,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/prts_upd.sv
`timescale 1ns / 1ps
module prts_upd (
   input  prts_pkg::slot_view_type view,
   output prts_pkg::slot_upd_type  upd
);
   import prts_pkg::*;

   logic [CNT_W-1:0] cd;
   logic [CNT_W-1:0] per;

   // Unwritten entries read as zero
   assign cd  = view.written ? view.entry.cd  : '0;
   assign per = view.written ? view.entry.per : '0;

   // Active slot: release on zero when occupied, else count a nonzero countdown down
   always_comb begin
      upd.wr          = 1'b0;
      upd.release_hit = 1'b0;
      upd.entry.per   = per;
      upd.entry.cd    = cd;
      if (view.active) begin
         if (cd == '0) begin
            if (view.occupied) begin
               upd.wr          = 1'b1;
               upd.release_hit = 1'b1;
               upd.entry.cd    = per - CNT_W'(1);
            end
         end else begin
            upd.wr       = 1'b1;
            upd.entry.cd = cd - CNT_W'(1);
         end
      end
   end

endmodule
